// ----- rtl/core/cgs_pkg.sv -----
// Shared widths and register codes for the clipped gradient step unit.
package cgs_pkg;

	// Element index and value widths.
	localparam int IDX_W = 6;
	localparam int VAL_W = 32;

	// Norm and square sum widths.
	localparam int ROOT_W = 32;
	localparam int SUM_W  = 64;

	// Configuration register widths.
	localparam int THR_W = 31;
	localparam int CNT_W = 7;

	// Configuration register indexes.
	localparam logic [1:0] REG_CLIP_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_LEARNING_RATE  = 2'd1;
	localparam logic [1:0] REG_ACTIVE_COUNT   = 2'd2;

	// Input word commands.
	localparam logic CMD_PARAM = 1'b0;
	localparam logic CMD_GRAD  = 1'b1;

	// Handshake between the sequencer and an iterative unit.
	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;

endpackage

// ----- rtl/core/clipped_gradient_step_unit.sv -----
// Top level: SGD step with L2-norm gradient clipping, shared multiplier and sequencer.
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_stall   | command, element_index, element_value
//  out     | output    | out_valid / out_stall | updated_index, updated_value, last_of_run
//  cfg     | input     | APB psel / penable    | clip_threshold, learning_rate, active_count
//
// A load word is stored when accepted. A trigger word runs read, multiply and
// accumulate per element for the sum of squares, the serial square root, then per
// element read, magnitude, clip multiply and divide when clipping, step multiply, add
// and emit. The single 32x32 multiplier and the two serial units set this order.
// Reset clears control state and loads register defaults; the stores are not cleared.
// in_stall is high for the whole update run; out_stall holds the current output word.
module clipped_gradient_step_unit #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [cgs_pkg::IDX_W-1:0]     element_index,
	input  logic signed [cgs_pkg::VAL_W-1:0] element_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cgs_pkg::IDX_W-1:0]     updated_index,
	output logic signed [cgs_pkg::VAL_W-1:0] updated_value,
	output logic                          last_of_run,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int XW = (AW > cgs_pkg::IDX_W) ? AW : cgs_pkg::IDX_W;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SQ_RD    = 4'd1;
	localparam logic [3:0] S_SQ_MUL   = 4'd2;
	localparam logic [3:0] S_SQ_ACC   = 4'd3;
	localparam logic [3:0] S_SQRT     = 4'd4;
	localparam logic [3:0] S_UP_RD    = 4'd5;
	localparam logic [3:0] S_UP_MAG   = 4'd6;
	localparam logic [3:0] S_CLIP_MUL = 4'd7;
	localparam logic [3:0] S_DIV_GO   = 4'd8;
	localparam logic [3:0] S_DIV_WAIT = 4'd9;
	localparam logic [3:0] S_STEP_MUL = 4'd10;
	localparam logic [3:0] S_ADD      = 4'd11;
	localparam logic [3:0] S_EMIT     = 4'd12;

	logic [3:0]                      state_q;
	logic [cgs_pkg::THR_W-1:0]       thr_q;
	logic signed [cgs_pkg::VAL_W-1:0] lr_q;
	logic [cgs_pkg::CNT_W-1:0]       cnt_q;
	logic [cgs_pkg::IDX_W-1:0]       i_q;
	logic [cgs_pkg::SUM_W-1:0]       sum_q;
	logic [cgs_pkg::ROOT_W-1:0]      norm_q;
	logic                            clip_q;
	logic [cgs_pkg::VAL_W-1:0]       gm_q;
	logic [2*cgs_pkg::VAL_W-1:0]     prod_q;
	logic signed [cgs_pkg::VAL_W-1:0] g_q;
	logic signed [cgs_pkg::VAL_W-1:0] p_q;
	logic [cgs_pkg::IDX_W-1:0]       oidx_q;
	logic signed [cgs_pkg::VAL_W-1:0] oval_q;
	logic                            olast_q;

	logic signed [cgs_pkg::VAL_W-1:0] param_mem [MAX_ELEMENTS];
	logic signed [cgs_pkg::VAL_W-1:0] grad_mem  [MAX_ELEMENTS];

	logic                            in_acc;
	logic                            cfg_wr;
	logic [cgs_pkg::CNT_W-1:0]       n_m1;
	logic                            in_range;
	logic                            trigger;
	logic                            last_elem;
	logic [XW-1:0]                   in_x;
	logic [XW-1:0]                   i_x;
	logic [AW-1:0]                   in_addr;
	logic [AW-1:0]                   rd_addr;
	logic [cgs_pkg::VAL_W-1:0]       g_mag;
	logic [cgs_pkg::VAL_W-1:0]       lr_mag;
	logic [cgs_pkg::VAL_W-1:0]       mul_a;
	logic [cgs_pkg::VAL_W-1:0]       mul_b;
	logic [cgs_pkg::SUM_W:0]         sum_add;
	logic                            step_neg;
	logic signed [cgs_pkg::SUM_W-15:0] step_s;
	logic signed [cgs_pkg::SUM_W-15:0] res_w;
	logic signed [cgs_pkg::VAL_W-1:0] res_sat;
	logic [cgs_pkg::ROOT_W-1:0]      root;
	logic [cgs_pkg::VAL_W-1:0]       quo;
	cgs_pkg::unit_ctl_t              sqrt_ctl;
	cgs_pkg::unit_ctl_t              div_ctl;

	// Handshakes and trigger decode.
	always_comb begin
		in_acc    = in_valid && !in_stall;
		cfg_wr    = psel && penable && pwrite && pready;
		n_m1      = (cnt_q == '0) ? '0 : (cnt_q - 7'd1);
		in_x      = XW'(element_index);
		i_x       = XW'(i_q);
		in_addr   = in_x[AW-1:0];
		rd_addr   = i_x[AW-1:0];
		in_range  = ((XW + 1)'(element_index) < (XW + 1)'(MAX_ELEMENTS));
		trigger   = (command == cgs_pkg::CMD_GRAD) && in_range
			&& ({1'b0, element_index} == n_m1);
		last_elem = ({1'b0, i_q} == n_m1);
	end

	assign in_stall = (state_q != S_IDLE);
	assign pready   = 1'b1;

	// Register readback.
	always_comb begin
		case (paddr[3:2])
			cgs_pkg::REG_CLIP_THRESHOLD: prdata = {1'b0, thr_q};
			cgs_pkg::REG_LEARNING_RATE:  prdata = lr_q;
			cgs_pkg::REG_ACTIVE_COUNT:   prdata = {25'd0, cnt_q};
			default:                     prdata = '0;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 31'd65536;
			lr_q  <= 32'sd655;
			cnt_q <= 7'd64;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				cgs_pkg::REG_CLIP_THRESHOLD: thr_q <= pwdata[cgs_pkg::THR_W-1:0];
				cgs_pkg::REG_LEARNING_RATE:  lr_q  <= pwdata;
				cgs_pkg::REG_ACTIVE_COUNT:   cnt_q <= pwdata[cgs_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Parameter and gradient stores with registered reads.
	always_ff @(posedge clk) begin
		if (in_acc && in_range && (command == cgs_pkg::CMD_PARAM)) begin
			param_mem[in_addr] <= element_value;
		end else if (state_q == S_ADD) begin
			param_mem[rd_addr] <= res_sat;
		end
		if (in_acc && in_range && (command == cgs_pkg::CMD_GRAD)) begin
			grad_mem[in_addr] <= element_value;
		end
		g_q <= grad_mem[rd_addr];
		p_q <= param_mem[rd_addr];
	end

	// Shared multiplier operand selection.
	always_comb begin
		g_mag  = g_q[cgs_pkg::VAL_W-1] ? (32'd0 - g_q) : g_q;
		lr_mag = lr_q[cgs_pkg::VAL_W-1] ? (32'd0 - lr_q) : lr_q;
		case (state_q)
			S_SQ_MUL:   begin mul_a = g_mag; mul_b = g_mag; end
			S_CLIP_MUL: begin mul_a = gm_q;  mul_b = {1'b0, thr_q}; end
			default:    begin mul_a = gm_q;  mul_b = lr_mag; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Saturating accumulate and saturating parameter update.
	always_comb begin
		sum_add  = {1'b0, sum_q} + {1'b0, prod_q};
		step_neg = g_q[cgs_pkg::VAL_W-1] ^ lr_q[cgs_pkg::VAL_W-1];
		step_s   = $signed({2'b00, prod_q[2*cgs_pkg::VAL_W-1:16]});
		if (step_neg) begin
			step_s = -step_s;
		end
		res_w = 50'(p_q) + step_s;
		if (res_w > 50'sd2147483647) begin
			res_sat = 32'sh7FFFFFFF;
		end else if (res_w < -50'sd2147483648) begin
			res_sat = 32'sh80000000;
		end else begin
			res_sat = res_w[cgs_pkg::VAL_W-1:0];
		end
	end

	assign sqrt_ctl.start = (state_q == S_SQ_ACC) && last_elem;
	assign div_ctl.start  = (state_q == S_DIV_GO);

	cgs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_ctl.start),
		.radicand (sum_add[cgs_pkg::SUM_W] ? {cgs_pkg::SUM_W{1'b1}} : sum_add[cgs_pkg::SUM_W-1:0]),
		.done     (sqrt_ctl.done),
		.root     (root)
	);

	cgs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_ctl.start),
		.dividend (prod_q[2*cgs_pkg::VAL_W-2:0]),
		.divisor  (norm_q),
		.done     (div_ctl.done),
		.quotient (quo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			sum_q   <= '0;
			clip_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && trigger) begin
						i_q     <= '0;
						sum_q   <= '0;
						state_q <= S_SQ_RD;
					end
				end
				S_SQ_RD:  state_q <= S_SQ_MUL;
				S_SQ_MUL: state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					sum_q <= sum_add[cgs_pkg::SUM_W] ? {cgs_pkg::SUM_W{1'b1}}
						: sum_add[cgs_pkg::SUM_W-1:0];
					if (last_elem) begin
						state_q <= S_SQRT;
					end else begin
						i_q     <= i_q + 6'd1;
						state_q <= S_SQ_RD;
					end
				end
				S_SQRT: begin
					if (sqrt_ctl.done) begin
						clip_q  <= (root > {1'b0, thr_q});
						i_q     <= '0;
						state_q <= S_UP_RD;
					end
				end
				S_UP_RD:    state_q <= S_UP_MAG;
				S_UP_MAG:   state_q <= clip_q ? S_CLIP_MUL : S_STEP_MUL;
				S_CLIP_MUL: state_q <= S_DIV_GO;
				S_DIV_GO:   state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_ctl.done) begin
						state_q <= S_STEP_MUL;
					end
				end
				S_STEP_MUL: state_q <= S_ADD;
				S_ADD:      state_q <= S_EMIT;
				S_EMIT: begin
					if (!out_stall) begin
						if (last_elem) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 6'd1;
							state_q <= S_UP_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the update pass.
	always_ff @(posedge clk) begin
		if (state_q == S_SQRT && sqrt_ctl.done) begin
			norm_q <= root;
		end
		if (state_q == S_UP_MAG) begin
			gm_q <= g_mag;
		end else if (state_q == S_DIV_WAIT && div_ctl.done) begin
			gm_q <= quo;
		end
		if (state_q == S_ADD) begin
			oidx_q  <= i_q;
			oval_q  <= res_sat;
			olast_q <= last_elem;
		end
	end

	assign out_valid     = (state_q == S_EMIT);
	assign updated_index = oidx_q;
	assign updated_value = oval_q;
	assign last_of_run   = olast_q;

	// The block takes no input while a word waits on the output.
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while output word pending");

	// A trigger word starts the sum of squares in the next cycle.
	a_trigger_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && trigger) |=> (state_q == S_SQ_RD && i_q == '0))
		else $error("trigger did not start the run");

	// The last word of a run returns the block to accepting input.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_of_run) |=> !in_stall)
		else $error("block stayed busy after last word");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside its wait state");

endmodule

// ----- rtl/core/cgs_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
module cgs_sqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [cgs_pkg::SUM_W-1:0]           radicand,
	output logic                                done,
	output logic [cgs_pkg::ROOT_W-1:0]          root
);

	logic [cgs_pkg::SUM_W-1:0]  rad_q;
	logic [cgs_pkg::ROOT_W+1:0] rem_q;
	logic [cgs_pkg::ROOT_W-1:0] root_q;
	logic [5:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [cgs_pkg::ROOT_W+1:0] rem_sh;
	logic [cgs_pkg::ROOT_W+1:0] trial;
	logic                       take;

	// One digit step: bring in two radicand bits and try the next root bit.
	always_comb begin
		rem_sh = {rem_q[cgs_pkg::ROOT_W-1:0], rad_q[cgs_pkg::SUM_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	// Step sequencing over all root bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(cgs_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[cgs_pkg::SUM_W-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[cgs_pkg::ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- rtl/core/cgs_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module cgs_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [2*cgs_pkg::VAL_W-2:0]         dividend,
	input  logic [cgs_pkg::ROOT_W-1:0]          divisor,
	output logic                                done,
	output logic [cgs_pkg::VAL_W-1:0]           quotient
);

	logic [cgs_pkg::ROOT_W:0]   rem_q;
	logic [cgs_pkg::VAL_W-1:0]  dq_q;
	logic [cgs_pkg::ROOT_W-1:0] dvs_q;
	logic [5:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [cgs_pkg::ROOT_W:0]   rem_sh;
	logic                       take;

	// The quotient fits the value width, so the upper dividend bits start as remainder.
	always_comb begin
		rem_sh = {rem_q[cgs_pkg::ROOT_W-1:0], dq_q[cgs_pkg::VAL_W-1]};
		take   = (rem_sh >= {1'b0, dvs_q});
	end

	// Step sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(cgs_pkg::VAL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers; quotient bits shift into the low dividend bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b00, dividend[2*cgs_pkg::VAL_W-2:cgs_pkg::VAL_W]};
			dq_q  <= dividend[cgs_pkg::VAL_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			dq_q  <= {dq_q[cgs_pkg::VAL_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ----- sim/tb_clipped_gradient_step_unit.sv -----
// Testbench for the clipped gradient step unit: predicts every updated parameter and checks it.
module tb_clipped_gradient_step_unit;

	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [cgs_pkg::IDX_W-1:0] index;
		logic [cgs_pkg::VAL_W-1:0] value;
		logic                      last;
	} update_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic [cgs_pkg::IDX_W-1:0] element_index = '0;
	logic signed [cgs_pkg::VAL_W-1:0] element_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [cgs_pkg::IDX_W-1:0] updated_index;
	logic signed [cgs_pkg::VAL_W-1:0] updated_value;
	logic last_of_run;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	clipped_gradient_step_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .element_index(element_index), .element_value(element_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.updated_index(updated_index), .updated_value(updated_value),
		.last_of_run(last_of_run),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic [cgs_pkg::THR_W-1:0] threshold_q;
	logic signed [31:0] rate_q;
	logic [cgs_pkg::CNT_W-1:0] count_q;
	logic signed [31:0] param_mem [64];
	logic signed [31:0] grad_mem [64];
	update_word_t pending_updates [$];

	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_receiver = 1'b0;
	int hold_cycles = 0;

	// Integer square root of a 64-bit value.
	function automatic logic [31:0] root_of(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r[31:0];
	endfunction

	// Apply one accepted word to the predictor and queue the updates it causes.
	function automatic void predict_word(logic cmd, logic [cgs_pkg::IDX_W-1:0] idx,
			logic signed [31:0] v);
		int n;
		logic [63:0] sum;
		logic [63:0] sq;
		logic [63:0] gm;
		logic [63:0] pm;
		logic [63:0] rm;
		logic [31:0] norm;
		logic signed [63:0] res;
		bit neg;
		update_word_t w;
		n = (count_q == 0) ? 1 : count_q;
		if (cmd == cgs_pkg::CMD_PARAM) begin
			param_mem[idx] = v;
			return;
		end
		grad_mem[idx] = v;
		if (idx != n - 1) return;
		sum = 0;
		for (int i = 0; i < n; i++) begin
			gm = grad_mem[i] < 0 ? 64'(-64'(grad_mem[i])) : 64'(grad_mem[i]);
			sq = gm * gm;
			sum = (sum > ~64'd0 - sq) ? ~64'd0 : sum + sq;
		end
		norm = root_of(sum);
		rm = rate_q < 0 ? 64'(-64'(rate_q)) : 64'(rate_q);
		for (int i = 0; i < n; i++) begin
			gm = grad_mem[i] < 0 ? 64'(-64'(grad_mem[i])) : 64'(grad_mem[i]);
			if (norm > {1'b0, threshold_q}) gm = (gm * 64'(threshold_q)) / 64'(norm);
			pm = (gm * rm) >> 16;
			neg = (grad_mem[i] < 0) != (rate_q < 0);
			res = 64'(param_mem[i]) + (neg ? -$signed(pm) : $signed(pm));
			if (res > 64'sd2147483647) res = 64'sd2147483647;
			if (res < -64'sd2147483648) res = -64'sd2147483648;
			param_mem[i] = res[31:0];
			w.index = i[cgs_pkg::IDX_W-1:0];
			w.value = res[31:0];
			w.last = (i == n - 1);
			pending_updates.push_back(w);
		end
	endfunction

	// Receiver stall: random gaps, or a long hold when asked.
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_receiver && hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (r < 60) begin
			out_stall <= 1'b0;
		end else if (r < 97) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= (($urandom & 1) == 1);
		end
	end

	// Result checker and idle watchdog.
	always @(posedge clk) begin
		update_word_t want;
		bit accepted;
		accepted = (in_valid && !in_stall) || (out_valid && !out_stall);
		if (arst_n) idle_cycles <= accepted ? 0 : idle_cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected update: index %0d value %h last %0b",
						updated_index, updated_value, last_of_run);
			end else begin
				want = pending_updates.pop_front();
				if (want.index !== updated_index || want.value !== updated_value
						|| want.last !== last_of_run) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d %h %0b, got %0d %h %0b",
							want.index, want.value, want.last,
							updated_index, updated_value, last_of_run);
				end
			end
		end
	end

	// Send one word, with a random gap in front of it; valid stays up until the next drive.
	task automatic send_word(logic cmd, int idx, logic [31:0] v, bit gaps = 1);
		int gap;
		gap = 0;
		if (gaps) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) gap = 0;
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		element_index <= idx[cgs_pkg::IDX_W-1:0];
		element_value <= v;
		do @(posedge clk); while (in_stall);
		predict_word(cmd, idx[cgs_pkg::IDX_W-1:0], v);
	endtask

	// Drop valid, wait until every expected update has come, then let the block settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_updates.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	// One APB register write.
	task automatic write_reg(logic [1:0] code, logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {code, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (code)
			cgs_pkg::REG_CLIP_THRESHOLD: threshold_q = v[cgs_pkg::THR_W-1:0];
			cgs_pkg::REG_LEARNING_RATE:  rate_q = v;
			default:                     count_q = v[cgs_pkg::CNT_W-1:0];
		endcase
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 131072)) - 65536);
			2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			3: return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	// Load parameters for all active elements, then a full gradient vector.
	task automatic run_vector(int n, bit gaps = 1);
		for (int i = 0; i < n; i++) send_word(cgs_pkg::CMD_PARAM, i, rand_value(), gaps);
		for (int i = 0; i < n; i++) send_word(cgs_pkg::CMD_GRAD, i, rand_value(), gaps);
	endtask

	// Directed: extremes, clipping off and on, saturation, stray indexes, repeated trigger.
	task automatic test_directed();
		write_reg(cgs_pkg::REG_ACTIVE_COUNT, 32'd4);
		write_reg(cgs_pkg::REG_CLIP_THRESHOLD, 32'h7fffffff);
		write_reg(cgs_pkg::REG_LEARNING_RATE, 32'h00010000);
		send_word(cgs_pkg::CMD_PARAM, 0, 32'h7fffffff);
		send_word(cgs_pkg::CMD_PARAM, 1, 32'h80000000);
		send_word(cgs_pkg::CMD_PARAM, 2, 32'h0);
		send_word(cgs_pkg::CMD_PARAM, 3, 32'hffffffff);
		send_word(cgs_pkg::CMD_GRAD, 0, 32'h7fffffff);
		send_word(cgs_pkg::CMD_GRAD, 1, 32'h80000000);
		send_word(cgs_pkg::CMD_GRAD, 2, 32'h00010000);
		send_word(cgs_pkg::CMD_GRAD, 9, 32'h12345678);
		send_word(cgs_pkg::CMD_PARAM, 63, 32'h5a5a5a5a);
		send_word(cgs_pkg::CMD_GRAD, 3, 32'hffff0000);
		drain();
		write_reg(cgs_pkg::REG_CLIP_THRESHOLD, 32'd0);
		write_reg(cgs_pkg::REG_LEARNING_RATE, 32'h80000000);
		send_word(cgs_pkg::CMD_GRAD, 3, 32'h00020000);
		send_word(cgs_pkg::CMD_GRAD, 3, 32'h0);
		drain();
		write_reg(cgs_pkg::REG_ACTIVE_COUNT, 32'd0);
		write_reg(cgs_pkg::REG_CLIP_THRESHOLD, 32'd65536);
		write_reg(cgs_pkg::REG_LEARNING_RATE, 32'h7fffffff);
		send_word(cgs_pkg::CMD_GRAD, 0, 32'h00030000);
		drain();
		write_reg(cgs_pkg::REG_ACTIVE_COUNT, 32'd1);
		send_word(cgs_pkg::CMD_GRAD, 0, 32'hfffd0000);
		drain();
	endtask

	// Full-width vector: largest active count and all index bits.
	task automatic test_full_vector();
		write_reg(cgs_pkg::REG_ACTIVE_COUNT, 32'd64);
		write_reg(cgs_pkg::REG_LEARNING_RATE, 32'd655);
		write_reg(cgs_pkg::REG_CLIP_THRESHOLD, 32'h00040000);
		run_vector(64);
		drain();
	endtask

	// Oversize active count: nothing triggers.
	task automatic test_large_count();
		write_reg(cgs_pkg::REG_ACTIVE_COUNT, 32'd127);
		for (int i = 0; i < 6; i++) send_word(cgs_pkg::CMD_GRAD, 63 - i, rand_value());
		drain();
	endtask

	// Receiver held off while the sender keeps offering words.
	task automatic test_backpressure();
		write_reg(cgs_pkg::REG_ACTIVE_COUNT, 32'd3);
		write_reg(cgs_pkg::REG_CLIP_THRESHOLD, $urandom & 32'h7fffffff);
		hold_cycles = 400;
		hold_receiver = 1'b1;
		run_vector(3, 0);
		send_word(cgs_pkg::CMD_GRAD, 2, rand_value(), 0);
		send_word(cgs_pkg::CMD_GRAD, 2, rand_value(), 0);
		hold_receiver = 1'b0;
		drain();
	endtask

	// Random phases with mostly small vectors and random settings.
	task automatic test_random();
		int n;
		int sent;
		sent = 0;
		while (sent < 170) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
			write_reg(cgs_pkg::REG_ACTIVE_COUNT, n);
			write_reg(cgs_pkg::REG_LEARNING_RATE, ($urandom_range(0, 1) == 1) ? $urandom
				: 32'($signed($urandom_range(0, 131072)) - 65536));
			write_reg(cgs_pkg::REG_CLIP_THRESHOLD,
				($urandom_range(0, 2) == 0) ? ($urandom & 32'h7fffffff)
				: $urandom_range(0, 32'h00080000));
			run_vector(n);
			sent += 2 * n;
			// Re-trigger with stale gradients, plus some noise words.
			repeat ($urandom_range(0, 3)) begin
				case ($urandom_range(0, 2))
					0: send_word(cgs_pkg::CMD_GRAD, n - 1, rand_value());
					1: send_word(cgs_pkg::CMD_PARAM, $urandom_range(0, n - 1), rand_value());
					default: send_word(cgs_pkg::CMD_GRAD, $urandom_range(n, 63), rand_value());
				endcase
				sent++;
			end
			drain();
		end
	endtask

	// Watchdog on cycles without any accepted word.
	initial begin
		wait (arst_n);
		wait (idle_cycles >= IDLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		threshold_q = 31'd65536;
		rate_q = 32'sd655;
		count_q = 7'd64;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_vector();
		test_large_count();
		test_backpressure();
		test_random();
		drain();
		if (mismatches == 0 && pending_updates.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/cgs_pkg.sv
rtl/core/cgs_sqrt.sv
rtl/core/cgs_div.sv
rtl/core/clipped_gradient_step_unit.sv
sim/tb_clipped_gradient_step_unit.sv
